// ----- hdl/usrh_pkg.sv -----
// ----------------------------------------------------------------------------
// usrh_pkg
// shared types and codes for the usb standard request handler
// ----------------------------------------------------------------------------
package usrh_pkg;

  // response actions
  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_STATUS = 2'd1;
  localparam logic [1:0] ACT_DATA   = 2'd2;
  localparam logic [1:0] ACT_STALL  = 2'd3;

  // class layer notifications
  localparam logic [1:0] CC_NONE   = 2'd0;
  localparam logic [1:0] CC_SETUP  = 2'd1;
  localparam logic [1:0] CC_INIT   = 2'd2;
  localparam logic [1:0] CC_DEINIT = 2'd3;

  // device states
  localparam logic [1:0] ST_DEFAULT    = 2'd0;
  localparam logic [1:0] ST_ADDRESSED  = 2'd1;
  localparam logic [1:0] ST_CONFIGURED = 2'd2;

  // recipients
  localparam logic [1:0] RCP_DEVICE    = 2'd0;
  localparam logic [1:0] RCP_INTERFACE = 2'd1;
  localparam logic [1:0] RCP_ENDPOINT  = 2'd2;
  localparam logic [1:0] RCP_OTHER     = 2'd3;

  // standard request codes
  localparam logic [7:0] REQ_GET_STATUS        = 8'd0;
  localparam logic [7:0] REQ_CLEAR_FEATURE     = 8'd1;
  localparam logic [7:0] REQ_SET_FEATURE       = 8'd3;
  localparam logic [7:0] REQ_SET_ADDRESS       = 8'd5;
  localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
  localparam logic [7:0] REQ_GET_CONFIGURATION = 8'd8;
  localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;

  // descriptor types
  localparam logic [7:0] DT_DEVICE      = 8'd1;
  localparam logic [7:0] DT_CONFIG      = 8'd2;
  localparam logic [7:0] DT_STRING      = 8'd3;
  localparam logic [7:0] DT_QUALIFIER   = 8'd6;
  localparam logic [7:0] DT_OTHER_SPEED = 8'd7;
  localparam logic [7:0] STRING_LAST    = 8'h05;

  // descriptor selector codes
  localparam logic [3:0] SEL_NONE        = 4'd0;
  localparam logic [3:0] SEL_DEVICE      = 4'd1;
  localparam logic [3:0] SEL_CONFIG      = 4'd2;
  localparam logic [3:0] SEL_QUALIFIER   = 4'd3;
  localparam logic [3:0] SEL_OTHER_SPEED = 4'd4;
  localparam logic [3:0] SEL_STRING0     = 4'd5;

  // feature selectors
  localparam logic [15:0] FEAT_EP_HALT       = 16'd0;
  localparam logic [15:0] FEAT_REMOTE_WAKEUP = 16'd1;

  // device limits
  localparam logic [7:0] MAX_INTERFACES    = 8'd1;
  localparam logic [7:0] MAX_CONFIGURATION = 8'd1;

  // one decoded setup word
  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  request_code;
    logic [15:0] value_word;
    logic [15:0] index_word;
    logic [15:0] length_word;
    logic        class_refuses_config;
  } setup_t;

  // device state held between words
  typedef struct packed {
    logic [1:0] state;
    logic [6:0] address;
    logic [7:0] config_num;
    logic       remote_wakeup;
  } dev_t;

  // reply fields
  typedef struct packed {
    logic [1:0]  action;
    logic [1:0]  class_call;
    logic [3:0]  select;
    logic [15:0] length;
    logic [15:0] value;
    logic        addr_upd;
  } reply_t;

endpackage

// ----- hdl/usrh_decode.sv -----
// ----------------------------------------------------------------------------
// usrh_decode
// single-pass decode of one setup word against the current device state
// ----------------------------------------------------------------------------
module usrh_decode #(
  parameter int ENDPOINTS = 16
) (
  input  usrh_pkg::setup_t     setup,
  input  usrh_pkg::dev_t       dev,
  input  logic                 class_present,
  input  logic [ENDPOINTS-1:0] halt_out,
  input  logic [ENDPOINTS-1:0] halt_in,
  output usrh_pkg::reply_t     reply,
  output usrh_pkg::dev_t       dev_next,
  output logic [ENDPOINTS-1:0] halt_out_next,
  output logic [ENDPOINTS-1:0] halt_in_next
);
  import usrh_pkg::*;

  logic [7:0] desc_type;
  logic [7:0] desc_idx;
  logic [3:0] sel;
  logic       needs_class;
  logic [1:0] fwd;
  logic [3:0] ep_num;
  logic       ep_in;
  logic       ep_halted;
  logic       ep_set;
  logic       ep_clr;
  logic [7:0] cfg_req;

  assign desc_type = setup.value_word[15:8];
  assign desc_idx  = setup.value_word[7:0];
  assign cfg_req   = setup.value_word[7:0];
  assign fwd       = class_present ? CC_SETUP : CC_NONE;
  assign ep_num    = setup.index_word[3:0];
  assign ep_in     = setup.index_word[7];

  // descriptor selector
  always_comb begin
    sel         = SEL_NONE;
    needs_class = 1'b0;
    priority if (desc_type == DT_DEVICE) begin
      sel = SEL_DEVICE;
    end else if (desc_type == DT_CONFIG) begin
      sel         = SEL_CONFIG;
      needs_class = 1'b1;
    end else if (desc_type == DT_QUALIFIER) begin
      sel         = SEL_QUALIFIER;
      needs_class = 1'b1;
    end else if (desc_type == DT_OTHER_SPEED) begin
      sel         = SEL_OTHER_SPEED;
      needs_class = 1'b1;
    end else if (desc_type == DT_STRING && desc_idx <= STRING_LAST) begin
      sel = SEL_STRING0 + desc_idx[3:0];
    end else begin
      sel = SEL_NONE;
    end
  end

  // halt bit lookup, endpoints past the limit read as clear
  always_comb begin
    ep_halted = 1'b0;
    for (int e = 0; e < ENDPOINTS; e++) begin
      if (ep_num == 4'(e)) begin
        ep_halted = ep_in ? halt_in[e] : halt_out[e];
      end
    end
  end

  // request dispatch
  always_comb begin
    reply    = '0;
    dev_next = dev;
    ep_set   = 1'b0;
    ep_clr   = 1'b0;
    unique case (setup.mode)
      RCP_DEVICE: begin
        unique case (setup.request_code)
          REQ_GET_DESCRIPTOR: begin
            if (sel == SEL_NONE || (needs_class && !class_present)) begin
              reply.action = ACT_STALL;
            end else if (setup.length_word != 16'd0) begin
              reply.action = ACT_DATA;
              reply.select = sel;
              reply.length = setup.length_word;
            end
          end
          REQ_SET_ADDRESS: begin
            if (setup.index_word == 16'd0 && setup.length_word == 16'd0 &&
                setup.value_word[15:7] == 9'd0) begin
              dev_next.address = setup.value_word[6:0];
              dev_next.state   = (setup.value_word != 16'd0) ? ST_ADDRESSED : ST_DEFAULT;
              reply.addr_upd   = 1'b1;
              reply.action     = ACT_STATUS;
            end else begin
              reply.action = ACT_STALL;
            end
          end
          REQ_SET_CONFIGURATION: begin
            if (cfg_req > MAX_CONFIGURATION) begin
              reply.action = ACT_STALL;
            end else begin
              dev_next.config_num = cfg_req;
              reply.action        = ACT_STATUS;
              if (cfg_req == 8'd0) begin
                dev_next.state = ST_ADDRESSED;
                if (class_present) reply.class_call = CC_DEINIT;
              end else begin
                dev_next.state = ST_CONFIGURED;
                if (class_present) begin
                  reply.class_call = CC_INIT;
                  if (setup.class_refuses_config) reply.action = ACT_STALL;
                end
              end
            end
          end
          REQ_GET_CONFIGURATION: begin
            if (setup.length_word != 16'd1) begin
              reply.action = ACT_STALL;
            end else begin
              reply.action = ACT_DATA;
              reply.length = 16'd1;
              reply.value  = {8'd0, dev.config_num};
            end
          end
          REQ_GET_STATUS: begin
            if (setup.length_word != 16'd2) begin
              reply.action = ACT_STALL;
            end else begin
              reply.action = ACT_DATA;
              reply.length = 16'd2;
              reply.value  = {14'd0, dev.remote_wakeup, 1'b0};
            end
          end
          REQ_SET_FEATURE: begin
            if (setup.value_word == FEAT_REMOTE_WAKEUP) begin
              dev_next.remote_wakeup = 1'b1;
              reply.class_call       = fwd;
              reply.action           = ACT_STATUS;
            end
          end
          REQ_CLEAR_FEATURE: begin
            if (setup.value_word == FEAT_REMOTE_WAKEUP) begin
              dev_next.remote_wakeup = 1'b0;
              reply.class_call       = fwd;
              reply.action           = ACT_STATUS;
            end else begin
              reply.action = ACT_STALL;
            end
          end
          default: begin
            reply.action = ACT_STALL;
          end
        endcase
      end
      RCP_INTERFACE: begin
        if (dev.state == ST_CONFIGURED && setup.index_word[7:0] < MAX_INTERFACES) begin
          reply.class_call = fwd;
          if (setup.length_word == 16'd0) reply.action = ACT_STATUS;
        end else begin
          reply.action = ACT_STALL;
        end
      end
      RCP_ENDPOINT: begin
        unique case (setup.request_code)
          REQ_GET_STATUS: begin
            reply.action = ACT_DATA;
            reply.length = 16'd2;
            reply.value  = {15'd0, ep_halted};
          end
          REQ_CLEAR_FEATURE: begin
            if (setup.value_word == FEAT_EP_HALT) begin
              ep_clr           = 1'b1;
              reply.class_call = fwd;
              reply.action     = ACT_STATUS;
            end
          end
          REQ_SET_FEATURE: begin
            if (setup.value_word == FEAT_EP_HALT) begin
              ep_set       = 1'b1;
              reply.action = ACT_STATUS;
            end
          end
          default: begin
            reply.action = ACT_NONE;
          end
        endcase
      end
      RCP_OTHER: begin
        reply.action = ACT_STALL;
      end
    endcase
  end

  // halt bit update per endpoint lane
  always_comb begin
    halt_out_next = halt_out;
    halt_in_next  = halt_in;
    for (int e = 0; e < ENDPOINTS; e++) begin
      if (ep_num == 4'(e) && (ep_set || ep_clr)) begin
        if (ep_in) halt_in_next[e] = ep_set;
        else       halt_out_next[e] = ep_set;
      end
    end
  end

endmodule

// ----- hdl/usb_standard_request_handler_top.sv -----
// ----------------------------------------------------------------------------
// usb_standard_request_handler_top
// chapter 9 standard request handler: one decoded setup word in, one reply out
// ----------------------------------------------------------------------------
//  channel  dir  handshake             payload
//  setup    in   in_valid / in_stall   mode, request_code, value/index/length, refuse
//  reply    out  out_valid / out_stall action, class_call, descriptor_select, ...
//  config   in   cfg_write             cfg_data (class_present)
//
//  a word is registered on entry and decoded into the reply register when the
//  reply stage advances; one word per cycle is sustained while the reply is
//  not stalled. the device state updates in the same cycle as the reply.
//  synchronous reset clears device state, halt bits and both valid flags,
//  and sets class_present. a stalled reply holds the input stage; a new word
//  is still taken while the input register is empty.
// ----------------------------------------------------------------------------
module usb_standard_request_handler_top #(
  parameter int ENDPOINTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [7:0]  request_code,
  input  logic [15:0] value_word,
  input  logic [15:0] index_word,
  input  logic [15:0] length_word,
  input  logic        class_refuses_config,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  action,
  output logic [1:0]  class_call,
  output logic [3:0]  descriptor_select,
  output logic [15:0] data_length,
  output logic [15:0] data_value,
  output logic        address_update,
  output logic [6:0]  device_address,
  output logic [1:0]  device_state_out
);
  import usrh_pkg::*;

  logic                 class_present;
  logic                 in_full;
  setup_t               setup;
  dev_t                 dev;
  dev_t                 dev_next;
  logic [ENDPOINTS-1:0] halt_out;
  logic [ENDPOINTS-1:0] halt_in;
  logic [ENDPOINTS-1:0] halt_out_next;
  logic [ENDPOINTS-1:0] halt_in_next;
  reply_t               reply_next;
  reply_t               reply;
  logic [6:0]           addr_q;
  logic [1:0]           state_q;
  logic                 adv;
  logic                 in_take;

  // handshake
  assign adv      = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !adv;
  assign in_take  = in_valid && !in_stall;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      class_present <= 1'b1;
    end else if (cfg_write) begin
      class_present <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (adv) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      setup <= '{mode, request_code, value_word, index_word, length_word,
                 class_refuses_config};
    end
  end

  usrh_decode #(
    .ENDPOINTS(ENDPOINTS)
  ) u_decode (
    .setup         (setup),
    .dev           (dev),
    .class_present (class_present),
    .halt_out      (halt_out),
    .halt_in       (halt_in),
    .reply         (reply_next),
    .dev_next      (dev_next),
    .halt_out_next (halt_out_next),
    .halt_in_next  (halt_in_next)
  );

  // device state and halt bits
  always_ff @(posedge clk) begin
    if (rst) begin
      dev      <= '{ST_DEFAULT, 7'd0, 8'd0, 1'b0};
      halt_out <= '0;
      halt_in  <= '0;
    end else if (adv) begin
      dev      <= dev_next;
      halt_out <= halt_out_next;
      halt_in  <= halt_in_next;
    end
  end

  // reply register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      reply   <= reply_next;
      addr_q  <= dev_next.address;
      state_q <= dev_next.state;
    end
  end

  assign action            = reply.action;
  assign class_call        = reply.class_call;
  assign descriptor_select = reply.select;
  assign data_length       = reply.length;
  assign data_value        = reply.value;
  assign address_update    = reply.addr_upd;
  assign device_address    = addr_q;
  assign device_state_out  = state_q;

  // device state only moves with a decoded word
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(adv)) |-> $stable(dev))
    else $error("device state changed without a word");

  // never an undefined device state
  a_state_code: assert property (@(posedge clk) disable iff (rst)
    dev.state != 2'd3)
    else $error("device state code out of range");

  // an address update is always acknowledged by status
  a_addr_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && address_update) |-> (action == ACT_STATUS))
    else $error("address update without status");

  // a selected descriptor goes out as data
  a_desc_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && descriptor_select != SEL_NONE) |-> (action == ACT_DATA))
    else $error("descriptor selected without data action");

  // init call only lands in the configured state
  a_init_cfg: assert property (@(posedge clk) disable iff (rst)
    (out_valid && class_call == CC_INIT) |-> (device_state_out == ST_CONFIGURED))
    else $error("class init outside configured state");

endmodule

// ----- bench/usb_standard_request_handler_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// usb_standard_request_handler_top_test
// self-checking bench for the chapter 9 standard request handler: setup
// words go in from a queue, an in-bench model of the device framework
// predicts each reply, and a monitor compares the replies field by field
// across both class_present settings and three idle patterns
// ----------------------------------------------------------------------------
module usb_standard_request_handler_top_test;
  import usrh_pkg::*;

  localparam int EP_COUNT = 16;
  localparam int QUIET_LIMIT = 5000;
  localparam int SEGMENT_WORDS = 215;

  // expected reply, with the address and state that the block shows after it
  typedef struct packed {
    logic [1:0]  action;
    logic [1:0]  class_call;
    logic [3:0]  select;
    logic [15:0] length;
    logic [15:0] value;
    logic        addr_upd;
    logic [6:0]  address;
    logic [1:0]  state;
  } dev_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  mode = '0;
  logic [7:0]  request_code = '0;
  logic [15:0] value_word = '0;
  logic [15:0] index_word = '0;
  logic [15:0] length_word = '0;
  logic        class_refuses_config = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  action;
  logic [1:0]  class_call;
  logic [3:0]  descriptor_select;
  logic [15:0] data_length;
  logic [15:0] data_value;
  logic        address_update;
  logic [6:0]  device_address;
  logic [1:0]  device_state_out;

  // device framework state mirrored by the bench
  logic       class_on = 1'b1;
  logic [1:0] usb_state = ST_DEFAULT;
  logic [6:0] bus_addr = '0;
  logic [7:0] cur_config = '0;
  logic       wakeup_on = 1'b0;
  logic       ep_halted [32];

  setup_t     pending_words [$];
  dev_reply_t expected_replies [$];
  dev_reply_t want;
  setup_t     next_word;
  logic       took_word = 1'b0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         quiet_cycles = 0;
  int         mismatch_count = 0;

  usb_standard_request_handler_top #(.ENDPOINTS(EP_COUNT)) uut (.*);

  always #2 clk = ~clk;

  // apply one setup word to the mirrored device and return its reply
  function automatic dev_reply_t predict_reply(setup_t w);
    dev_reply_t r;
    logic [1:0] fwd;
    logic [7:0] ep_byte;
    logic [4:0] slot;
    logic       ep_ok;
    r = '0;
    fwd = class_on ? CC_SETUP : CC_NONE;
    case (w.mode)
      RCP_DEVICE: begin
        case (w.request_code)
          REQ_GET_DESCRIPTOR: begin
            case (w.value_word[15:8])
              DT_DEVICE:      r.select = SEL_DEVICE;
              DT_CONFIG:      r.select = SEL_CONFIG;
              DT_QUALIFIER:   r.select = SEL_QUALIFIER;
              DT_OTHER_SPEED: r.select = SEL_OTHER_SPEED;
              DT_STRING: begin
                if (w.value_word[7:0] <= STRING_LAST)
                  r.select = SEL_STRING0 + w.value_word[3:0];
              end
              default: r.select = SEL_NONE;
            endcase
            // config-like descriptors come from the class layer
            if (r.select == SEL_NONE || (!class_on && (r.select == SEL_CONFIG ||
                r.select == SEL_QUALIFIER || r.select == SEL_OTHER_SPEED))) begin
              r.action = ACT_STALL;
              r.select = SEL_NONE;
            end else if (w.length_word != 16'd0) begin
              r.action = ACT_DATA;
              r.length = w.length_word;
            end else begin
              r.select = SEL_NONE;
            end
          end
          REQ_SET_ADDRESS: begin
            if (w.index_word == 16'd0 && w.length_word == 16'd0 &&
                w.value_word < 16'd128) begin
              bus_addr = w.value_word[6:0];
              r.addr_upd = 1'b1;
              r.action = ACT_STATUS;
              usb_state = (w.value_word != 16'd0) ? ST_ADDRESSED : ST_DEFAULT;
            end else begin
              r.action = ACT_STALL;
            end
          end
          REQ_SET_CONFIGURATION: begin
            if (w.value_word[7:0] > MAX_CONFIGURATION) begin
              r.action = ACT_STALL;
            end else begin
              cur_config = w.value_word[7:0];
              r.action = ACT_STATUS;
              if (w.value_word[7:0] == 8'd0) begin
                usb_state = ST_ADDRESSED;
                if (class_on) r.class_call = CC_DEINIT;
              end else begin
                // a refused init still leaves the device configured
                usb_state = ST_CONFIGURED;
                if (class_on) begin
                  r.class_call = CC_INIT;
                  if (w.class_refuses_config) r.action = ACT_STALL;
                end
              end
            end
          end
          REQ_GET_CONFIGURATION: begin
            if (w.length_word != 16'd1) begin
              r.action = ACT_STALL;
            end else begin
              r.action = ACT_DATA;
              r.length = 16'd1;
              r.value = {8'd0, cur_config};
            end
          end
          REQ_GET_STATUS: begin
            if (w.length_word != 16'd2) begin
              r.action = ACT_STALL;
            end else begin
              r.action = ACT_DATA;
              r.length = 16'd2;
              r.value = {14'd0, wakeup_on, 1'b0};
            end
          end
          REQ_SET_FEATURE: begin
            if (w.value_word == FEAT_REMOTE_WAKEUP) begin
              wakeup_on = 1'b1;
              r.class_call = fwd;
              r.action = ACT_STATUS;
            end
          end
          REQ_CLEAR_FEATURE: begin
            if (w.value_word == FEAT_REMOTE_WAKEUP) begin
              wakeup_on = 1'b0;
              r.class_call = fwd;
              r.action = ACT_STATUS;
            end else begin
              r.action = ACT_STALL;
            end
          end
          default: r.action = ACT_STALL;
        endcase
      end
      RCP_INTERFACE: begin
        if (usb_state == ST_CONFIGURED && w.index_word[7:0] < MAX_INTERFACES) begin
          r.class_call = fwd;
          if (w.length_word == 16'd0) r.action = ACT_STATUS;
        end else begin
          r.action = ACT_STALL;
        end
      end
      RCP_ENDPOINT: begin
        // halt slot: endpoint number, plus 16 for the in direction
        ep_byte = w.index_word[7:0];
        slot = {ep_byte[7], ep_byte[3:0]};
        ep_ok = int'(ep_byte[3:0]) < EP_COUNT;
        case (w.request_code)
          REQ_GET_STATUS: begin
            r.action = ACT_DATA;
            r.length = 16'd2;
            r.value = {15'd0, ep_ok && ep_halted[slot]};
          end
          REQ_CLEAR_FEATURE: begin
            if (w.value_word == FEAT_EP_HALT) begin
              if (ep_ok) ep_halted[slot] = 1'b0;
              r.class_call = fwd;
              r.action = ACT_STATUS;
            end
          end
          REQ_SET_FEATURE: begin
            if (w.value_word == FEAT_EP_HALT) begin
              if (ep_ok) ep_halted[slot] = 1'b1;
              r.action = ACT_STATUS;
            end
          end
          default: r.action = ACT_NONE;
        endcase
      end
      default: r.action = ACT_STALL;
    endcase
    r.address = bus_addr;
    r.state = usb_state;
    return r;
  endfunction

  // random setup word, mostly well-formed standard requests
  function automatic setup_t random_word();
    setup_t w;
    int pick;
    w.mode = 2'($urandom_range(3));
    w.request_code = 8'($urandom_range(255));
    w.value_word = 16'($urandom_range(16'hFFFF));
    w.index_word = 16'($urandom_range(16'hFFFF));
    w.length_word = 16'($urandom_range(16'hFFFF));
    w.class_refuses_config = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 10) begin
      w.mode = RCP_DEVICE;
      w.request_code = REQ_SET_ADDRESS;
      if ($urandom_range(9) != 0) w.value_word = 16'($urandom_range(127));
      if ($urandom_range(9) != 0) w.index_word = 16'd0;
      if ($urandom_range(9) != 0) w.length_word = 16'd0;
    end else if (pick < 20) begin
      w.mode = RCP_DEVICE;
      w.request_code = REQ_SET_CONFIGURATION;
      if ($urandom_range(7) != 0)
        w.value_word = {($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'd0,
                        8'($urandom_range(1))};
    end else if (pick < 28) begin
      w.mode = RCP_DEVICE;
      w.request_code = REQ_GET_DESCRIPTOR;
      case ($urandom_range(5))
        0: w.value_word[15:8] = DT_DEVICE;
        1: w.value_word[15:8] = DT_CONFIG;
        2: w.value_word[15:8] = DT_QUALIFIER;
        3: w.value_word[15:8] = DT_OTHER_SPEED;
        4: w.value_word[15:8] = DT_STRING;
        default: ;
      endcase
      if ($urandom_range(1) == 1) w.value_word[7:0] = 8'($urandom_range(6));
      if ($urandom_range(3) == 0) w.length_word = 16'd0;
    end else if (pick < 34) begin
      w.mode = RCP_DEVICE;
      w.request_code = REQ_GET_CONFIGURATION;
      if ($urandom_range(4) != 0) w.length_word = 16'd1;
    end else if (pick < 40) begin
      w.mode = RCP_DEVICE;
      w.request_code = REQ_GET_STATUS;
      if ($urandom_range(4) != 0) w.length_word = 16'd2;
    end else if (pick < 48) begin
      w.mode = RCP_DEVICE;
      w.request_code = ($urandom_range(1) == 1) ? REQ_SET_FEATURE : REQ_CLEAR_FEATURE;
      if ($urandom_range(3) != 0) w.value_word = FEAT_REMOTE_WAKEUP;
      else if ($urandom_range(1) == 1) w.value_word = 16'($urandom_range(3));
    end else if (pick < 63) begin
      w.mode = RCP_INTERFACE;
      if ($urandom_range(4) != 0) w.index_word[7:0] = 8'd0;
      if ($urandom_range(1) == 1) w.length_word = 16'd0;
    end else if (pick < 83) begin
      w.mode = RCP_ENDPOINT;
      case ($urandom_range(3))
        0: w.request_code = REQ_GET_STATUS;
        1: w.request_code = REQ_CLEAR_FEATURE;
        2: w.request_code = REQ_SET_FEATURE;
        default: ;
      endcase
      if ($urandom_range(4) != 0) w.value_word = FEAT_EP_HALT;
      if ($urandom_range(2) != 0) w.index_word[7:0] = {w.index_word[7], 3'd0,
                                                       w.index_word[3:0]};
    end else if (pick < 88) begin
      w.mode = RCP_OTHER;
    end
    return w;
  endfunction

  task automatic add_word(input logic [1:0] m, input logic [7:0] req,
                          input logic [15:0] val, input logic [15:0] idx,
                          input logic [15:0] len, input logic refuse);
    pending_words.push_back('{m, req, val, idx, len, refuse});
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
      mismatch_count++;
    end
  endtask

  // hold the sender until every reply is in and the pipeline is empty
  task automatic drain_replies();
    while (pending_words.size() != 0 || in_valid || expected_replies.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_class_present(input logic on);
    drain_replies();
    cfg_write <= 1'b1;
    cfg_data <= on;
    @(negedge clk);
    cfg_write <= 1'b0;
    class_on = on;
  endtask

  // setup word driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || took_word) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_word = pending_words.pop_front();
        mode <= next_word.mode;
        request_code <= next_word.request_code;
        value_word <= next_word.value_word;
        index_word <= next_word.index_word;
        length_word <= next_word.length_word;
        class_refuses_config <= next_word.class_refuses_config;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // reply receiver back-pressure
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // reply checker and setup word capture
  always @(posedge clk) begin
    if (rst) begin
      took_word <= 1'b0;
    end else begin
      took_word <= in_valid && !in_stall;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (out_valid && !out_stall) begin
        if (expected_replies.size() == 0) begin
          $display("%0t: reply with none expected, expected nothing, actual action %0h",
                   $time, action);
          mismatch_count++;
        end else begin
          want = expected_replies.pop_front();
          check_field("action", want.action, action);
          check_field("class_call", want.class_call, class_call);
          check_field("descriptor_select", want.select, descriptor_select);
          check_field("data_length", want.length, data_length);
          check_field("data_value", want.value, data_value);
          check_field("address_update", want.addr_upd, address_update);
          check_field("device_address", want.address, device_address);
          check_field("device_state_out", want.state, device_state_out);
        end
      end
      if (in_valid && !in_stall)
        expected_replies.push_back(predict_reply({mode, request_code, value_word,
                                                  index_word, length_word,
                                                  class_refuses_config}));
    end
  end

  // watchdog on cycles with no word moving on either side
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    foreach (ep_halted[i]) ep_halted[i] = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 28;
    recv_idle_pct = 66;

    // directed words with the class handler present
    add_word(RCP_DEVICE, REQ_SET_FEATURE, FEAT_REMOTE_WAKEUP, 16'd0, 16'd0, 1'b0);
    add_word(RCP_DEVICE, REQ_GET_STATUS, 16'd0, 16'd0, 16'd2, 1'b0);
    add_word(RCP_DEVICE, REQ_SET_FEATURE, 16'd2, 16'd0, 16'd0, 1'b0);
    add_word(RCP_DEVICE, REQ_CLEAR_FEATURE, 16'd0, 16'd0, 16'd0, 1'b0);
    add_word(RCP_DEVICE, REQ_CLEAR_FEATURE, FEAT_REMOTE_WAKEUP, 16'd0, 16'd0, 1'b0);
    add_word(RCP_DEVICE, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    add_word(RCP_OTHER, REQ_GET_STATUS, 16'd0, 16'd0, 16'd2, 1'b0);
    add_word(RCP_INTERFACE, REQ_GET_STATUS, 16'd0, 16'd0, 16'd0, 1'b0);
    add_word(RCP_DEVICE, REQ_SET_ADDRESS, 16'd128, 16'd0, 16'd0, 1'b0);
    add_word(RCP_DEVICE, REQ_SET_ADDRESS, 16'd127, 16'd0, 16'd0, 1'b0);
    add_word(RCP_DEVICE, REQ_SET_CONFIGURATION, 16'd2, 16'd0, 16'd0, 1'b0);
    add_word(RCP_DEVICE, REQ_SET_CONFIGURATION, 16'd1, 16'd0, 16'd0, 1'b1);
    add_word(RCP_DEVICE, REQ_GET_CONFIGURATION, 16'd0, 16'd0, 16'd1, 1'b0);
    add_word(RCP_INTERFACE, 8'h0B, 16'd0, 16'd0, 16'd0, 1'b0);
    add_word(RCP_INTERFACE, 8'h0A, 16'd0, 16'd0, 16'hFFFF, 1'b0);
    add_word(RCP_INTERFACE, 8'h0B, 16'd0, 16'd1, 16'd0, 1'b0);
    add_word(RCP_DEVICE, REQ_GET_DESCRIPTOR, {DT_DEVICE, 8'd0}, 16'd0, 16'hFFFF, 1'b0);
    add_word(RCP_DEVICE, REQ_GET_DESCRIPTOR, {DT_STRING, STRING_LAST}, 16'h0409,
             16'd18, 1'b0);
    add_word(RCP_DEVICE, REQ_GET_DESCRIPTOR, {DT_STRING, 8'd6}, 16'd0, 16'd18, 1'b0);
    add_word(RCP_DEVICE, REQ_GET_DESCRIPTOR, {8'hFF, 8'd0}, 16'd0, 16'd64, 1'b0);
    add_word(RCP_DEVICE, REQ_GET_DESCRIPTOR, {DT_CONFIG, 8'd0}, 16'd0, 16'd0, 1'b0);
    add_word(RCP_ENDPOINT, REQ_SET_FEATURE, FEAT_EP_HALT, 16'h0081, 16'd0, 1'b0);
    add_word(RCP_ENDPOINT, REQ_GET_STATUS, 16'd0, 16'hFFF1, 16'd2, 1'b0);
    add_word(RCP_ENDPOINT, REQ_CLEAR_FEATURE, FEAT_EP_HALT, 16'h0081, 16'd0, 1'b0);
    add_word(RCP_ENDPOINT, REQ_SET_FEATURE, 16'd1, 16'h000F, 16'd0, 1'b0);
    add_word(RCP_DEVICE, REQ_SET_CONFIGURATION, 16'd0, 16'd0, 16'd0, 1'b0);

    // directed words with no class handler
    write_class_present(1'b0);
    add_word(RCP_DEVICE, REQ_GET_DESCRIPTOR, {DT_OTHER_SPEED, 8'd0}, 16'd0, 16'd10, 1'b0);
    add_word(RCP_DEVICE, REQ_SET_CONFIGURATION, 16'd1, 16'd0, 16'd0, 1'b1);
    add_word(RCP_DEVICE, REQ_SET_ADDRESS, 16'd0, 16'd0, 16'd0, 1'b0);

    // random segments: idle pattern changes every two, class handler toggles
    for (int seg = 0; seg < 6; seg++) begin
      write_class_present(1'((seg + 1) % 2));
      case (seg / 2)
        0: begin send_idle_pct = 28; recv_idle_pct = 66; end
        1: begin send_idle_pct = 66; recv_idle_pct = 28; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int n = 0; n < SEGMENT_WORDS; n++) pending_words.push_back(random_word());
    end

    drain_replies();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && expected_replies.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/usrh_pkg.sv
hdl/usrh_decode.sv
hdl/usb_standard_request_handler_top.sv
bench/usb_standard_request_handler_top_test.sv
